FILE: sv/mbrpt_pkg.sv
// mbrpt_pkg: shared types and constants for the MBR partition table parser.
// Used by mbrpt_result_unit and mbr_partition_table_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbrpt_pkg;

    localparam int TABLE_OFFSET = 'h1BE;
    localparam int TABLE_BYTES  = 64;
    localparam int SIG_OFFSET   = 510;

    localparam logic [7:0] SIG_BYTE0 = 8'h55;
    localparam logic [7:0] SIG_BYTE1 = 8'hAA;

    localparam logic [7:0] TYPE_T39   = 8'h39;
    localparam logic [7:0] TYPE_EXT2  = 8'h83;
    localparam logic [7:0] TYPE_DOS0  = 8'h01;
    localparam logic [7:0] TYPE_DOS1  = 8'h04;
    localparam logic [7:0] TYPE_DOS2  = 8'h06;
    localparam logic [7:0] TYPE_DOS3  = 8'h0b;
    localparam logic [7:0] TYPE_DOS4  = 8'h0c;
    localparam logic [7:0] TYPE_XLNK0 = 8'h05;
    localparam logic [7:0] TYPE_XLNK1 = 8'h0f;
    localparam logic [7:0] TYPE_XLNK2 = 8'h85;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_T39   = 2'd1;
    localparam logic [1:0] KIND_EXT2  = 2'd2;
    localparam logic [1:0] KIND_DOS   = 2'd3;

    // Readout steps per entry: type byte, four start bytes, four length bytes.
    localparam logic [3:0] STEP_TYPE       = 4'd0;
    localparam logic [3:0] STEP_START_LAST = 4'd4;
    localparam logic [3:0] STEP_LEN_LAST   = 4'd8;

    localparam logic [3:0] ENTRY_TYPE_BYTE  = 4'd4;
    localparam logic [3:0] ENTRY_START_BYTE = 4'd8;

    localparam logic [1:0] ENTRY_LAST = 2'd3;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       sector_start;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  entry_number;
        logic [1:0]  kind;
        logic [1:0]  kind_index;
        logic        is_extended;
        logic [31:0] start_sector;
        logic [31:0] length_sectors;
        logic [31:0] end_sector;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] entry;
        logic [3:0] step;
    } rd_tag_t;

    function automatic logic [1:0] type_kind(input logic [7:0] t);
        logic [1:0] k;
        k = KIND_OTHER;
        if (t == TYPE_T39)
            k = KIND_T39;
        else if (t == TYPE_EXT2)
            k = KIND_EXT2;
        else if (t inside {TYPE_DOS0, TYPE_DOS1, TYPE_DOS2, TYPE_DOS3, TYPE_DOS4})
            k = KIND_DOS;
        return k;
    endfunction

    function automatic logic type_is_link(input logic [7:0] t);
        return t inside {TYPE_XLNK0, TYPE_XLNK1, TYPE_XLNK2};
    endfunction

endpackage

`default_nettype wire

FILE: sv/mbrpt_result_unit.sv
// mbrpt_result_unit: assembles table entries from the readout byte stream,
// keeps per-kind counts and registers the result words. Depends on mbrpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbrpt_result_unit
    import mbrpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire rd_tag_t    rd,
    input  wire logic [7:0] rdata,
    input  wire logic       sig_err,
    output logic            result_valid,
    output result_t         result
);

    logic [7:0]  type_reg, type_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] len_reg, len_next;
    logic [1:0]  cnt_reg [3];
    logic [1:0]  cnt_next [3];
    logic [1:0]  cnt_base [3];
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    logic [1:0]  kind;
    logic [1:0]  kidx;
    logic [31:0] len_full;
    logic        entry_done;

    assign len_full   = {rdata, len_reg[31:8]};
    assign entry_done = rd.valid && (rd.step == STEP_LEN_LAST);
    assign kind       = type_kind(type_reg);

    always_comb
    begin
        type_next  = type_reg;
        start_next = start_reg;
        len_next   = len_reg;
        if (rd.valid)
        begin
            if (rd.step == STEP_TYPE)
                type_next = rdata;
            else if (rd.step <= STEP_START_LAST)
                start_next = {rdata, start_reg[31:8]};
            else
                len_next = len_full;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cnt_base[i] = (rd.entry == 2'd0) ? 2'd0 : cnt_reg[i];
            cnt_next[i] = cnt_reg[i];
        end
        kidx = 2'd0;
        if (kind != KIND_OTHER)
            kidx = cnt_base[kind - 2'd1];
        if (entry_done)
        begin
            for (int i = 0; i < 3; i++)
                cnt_next[i] = cnt_base[i];
            if (kind != KIND_OTHER)
                cnt_next[kind - 2'd1] = kidx + 2'd1;
        end
    end

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (sig_err)
        begin
            result_valid_next       = 1'b1;
            result_next             = '0;
            result_next.status      = 1'b1;
            result_next.last_result = 1'b1;
        end
        else if (entry_done)
        begin
            result_valid_next          = 1'b1;
            result_next.status         = 1'b0;
            result_next.entry_number   = rd.entry;
            result_next.kind           = kind;
            result_next.kind_index     = kidx;
            result_next.is_extended    = type_is_link(type_reg);
            result_next.start_sector   = start_reg;
            result_next.length_sectors = len_full;
            result_next.end_sector     = start_reg + len_full;
            result_next.last_result    = (rd.entry == ENTRY_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                cnt_reg[i] <= 2'd0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            for (int i = 0; i < 3; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        start_reg  <= start_next;
        len_reg    <= len_next;
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

FILE: sv/mbr_partition_table_parser.sv
// mbr_partition_table_parser: top level; byte position, table memory,
// signature check and entry readout. Depends on mbrpt_pkg, mbrpt_result_unit.
// Takes one byte word per cycle while busy is low. After the last sector byte:
// an error word in the next cycle, or four entry words, each read byte by byte
// through the single table memory read port. The readout runs while the next
// sector loads; busy rises only if that sector reaches the table offset first.
// The receiver cannot stall. Reset clears position, readout and counts.
`timescale 1ns / 1ps
`default_nettype none

module mbr_partition_table_parser
    import mbrpt_pkg::*;
#(
    parameter int SECTOR_BYTES = 512
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire item_t item,
    output logic       result_valid,
    output result_t    result
);

    localparam int POS_W = $clog2(SECTOR_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_BYTES - 1);
    localparam logic [POS_W-1:0] TBL_LO   = POS_W'(TABLE_OFFSET);
    localparam logic [POS_W-1:0] TBL_HI   = POS_W'(TABLE_OFFSET + TABLE_BYTES);
    localparam logic [POS_W-1:0] SIG0_POS = POS_W'(SIG_OFFSET);
    localparam logic [POS_W-1:0] SIG1_POS = POS_W'(SIG_OFFSET + 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       sig0_reg, sig0_next;
    logic [7:0]       sig1_reg, sig1_next;
    logic             drain_reg, drain_next;
    logic [1:0]       entry_reg, entry_next;
    logic [3:0]       step_reg, step_next;
    rd_tag_t          rd_reg, rd_next;

    logic [7:0] table_mem [0:TABLE_BYTES-1];
    logic [7:0] rdata_reg;

    logic             accept;
    logic [POS_W-1:0] pos_cur;
    logic [POS_W-1:0] tbl_off;
    logic             tbl_hit;
    logic             last_byte;
    logic [7:0]       sig0_eff;
    logic [7:0]       sig1_eff;
    logic             sig_ok;
    logic             sig_err;
    logic [3:0]       rd_off;
    logic [5:0]       raddr;

    assign busy      = (drain_reg || rd_reg.valid) && (pos_reg >= TBL_LO);
    assign accept    = start && !busy;
    assign pos_cur   = item.sector_start ? '0 : pos_reg;
    assign tbl_off   = pos_cur - TBL_LO;
    assign tbl_hit   = (pos_cur >= TBL_LO) && (pos_cur < TBL_HI);
    assign last_byte = (pos_cur == POS_LAST);

    assign sig0_eff = (pos_cur == SIG0_POS) ? item.byte_value : sig0_reg;
    assign sig1_eff = (pos_cur == SIG1_POS) ? item.byte_value : sig1_reg;
    assign sig_ok   = (sig0_eff == SIG_BYTE0) && (sig1_eff == SIG_BYTE1);
    assign sig_err  = accept && last_byte && !sig_ok;

    assign rd_off = (step_reg == STEP_TYPE) ? ENTRY_TYPE_BYTE
                                            : step_reg + (ENTRY_START_BYTE - 4'd1);
    assign raddr  = {entry_reg, rd_off};

    always_comb
    begin
        pos_next  = pos_reg;
        sig0_next = sig0_reg;
        sig1_next = sig1_reg;
        if (accept)
        begin
            pos_next = last_byte ? '0 : pos_cur + POS_W'(1);
            if (pos_cur == SIG0_POS)
                sig0_next = item.byte_value;
            if (pos_cur == SIG1_POS)
                sig1_next = item.byte_value;
        end
    end

    always_comb
    begin
        drain_next = drain_reg;
        entry_next = entry_reg;
        step_next  = step_reg;
        if (drain_reg)
        begin
            if (step_reg == STEP_LEN_LAST)
            begin
                step_next = STEP_TYPE;
                if (entry_reg == ENTRY_LAST)
                    drain_next = 1'b0;
                else
                    entry_next = entry_reg + 2'd1;
            end
            else
                step_next = step_reg + 4'd1;
        end
        if (accept && last_byte && sig_ok)
        begin
            drain_next = 1'b1;
            entry_next = 2'd0;
            step_next  = STEP_TYPE;
        end
        rd_next.valid = drain_reg;
        rd_next.entry = entry_reg;
        rd_next.step  = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            drain_reg <= 1'b0;
            entry_reg <= 2'd0;
            step_reg  <= STEP_TYPE;
            rd_reg    <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            drain_reg <= drain_next;
            entry_reg <= entry_next;
            step_reg  <= step_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sig0_reg <= sig0_next;
        sig1_reg <= sig1_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && tbl_hit)
            table_mem[tbl_off[5:0]] <= item.byte_value;
        if (drain_reg)
            rdata_reg <= table_mem[raddr];
    end

    mbrpt_result_unit u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd           (rd_reg),
        .rdata        (rdata_reg),
        .sig_err      (sig_err),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

FILE: dv/tb_mbr_partition_table_parser.sv
// tb_mbr_partition_table_parser: self-checking testbench for the MBR partition table parser.
// Streams whole and cut-short boot sectors into the block and checks every result word.
// Depends on mbrpt_pkg and mbr_partition_table_parser.
`timescale 1ns / 1ps

module tb_mbr_partition_table_parser;
    import mbrpt_pkg::*;

    localparam int SECTOR_BYTES   = 512;
    localparam int RANDOM_SECTORS = 28;
    localparam int DRAIN_CYCLES   = 60;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PRINT_LIMIT    = 40;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item = '0;
    logic    busy;
    logic    result_valid;
    result_t result;

    item_t   pending_words [$];
    result_t expected_words [$];

    logic [7:0] sector_buf [SECTOR_BYTES];

    // predictor state
    int unsigned sector_pos = 0;
    logic [7:0]  table_copy [TABLE_BYTES];
    logic [7:0]  sig_lo = '0;
    logic [7:0]  sig_hi = '0;

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int gap_left    = 0;

    mbr_partition_table_parser #(
        .SECTOR_BYTES(SECTOR_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("mismatch, cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    function automatic logic [1:0] classify_type(input logic [7:0] t);
        case (t)
            TYPE_T39:  return KIND_T39;
            TYPE_EXT2: return KIND_EXT2;
            TYPE_DOS0, TYPE_DOS1, TYPE_DOS2, TYPE_DOS3, TYPE_DOS4: return KIND_DOS;
            default:   return KIND_OTHER;
        endcase
    endfunction

    task automatic predict_word(input item_t w);
        int unsigned pos;
        int          e;
        int          base;
        result_t     r;
        logic [7:0]  t;
        logic [1:0]  k;
        logic [2:0]  seen [3];
        begin
            if (w.sector_start)
                sector_pos = 0;
            pos = sector_pos;
            if (pos >= TABLE_OFFSET && pos < TABLE_OFFSET + TABLE_BYTES)
                table_copy[pos - TABLE_OFFSET] = w.byte_value;
            else if (pos == SIG_OFFSET)
                sig_lo = w.byte_value;
            else if (pos == SIG_OFFSET + 1)
                sig_hi = w.byte_value;
            if (pos + 1 >= SECTOR_BYTES) begin
                sector_pos = 0;
                if (sig_lo != SIG_BYTE0 || sig_hi != SIG_BYTE1) begin
                    r = '0;
                    r.status = 1'b1;
                    r.last_result = 1'b1;
                    expected_words.push_back(r);
                end
                else begin
                    for (e = 0; e < 3; e++)
                        seen[e] = '0;
                    for (e = 0; e < 4; e++) begin
                        base = e * 16;
                        t = table_copy[base + 4];
                        k = classify_type(t);
                        r = '0;
                        r.entry_number = e[1:0];
                        r.kind = k;
                        if (k != KIND_OTHER) begin
                            r.kind_index = seen[k - 1][1:0];
                            seen[k - 1] = seen[k - 1] + 3'd1;
                        end
                        r.is_extended = (t == TYPE_XLNK0 || t == TYPE_XLNK1 || t == TYPE_XLNK2);
                        r.start_sector = {table_copy[base + 11], table_copy[base + 10],
                                          table_copy[base + 9], table_copy[base + 8]};
                        r.length_sectors = {table_copy[base + 15], table_copy[base + 14],
                                            table_copy[base + 13], table_copy[base + 12]};
                        r.end_sector = r.start_sector + r.length_sectors;
                        r.last_result = (e == 3);
                        expected_words.push_back(r);
                    end
                end
            end
            else
                sector_pos = pos + 1;
        end
    endtask

    // sector construction
    task automatic fill_sector(input bit rand_fill, input logic [7:0] value);
        for (int i = 0; i < SECTOR_BYTES; i++)
            sector_buf[i] = rand_fill ? 8'($urandom_range(0, 255)) : value;
        sector_buf[SIG_OFFSET]     = SIG_BYTE0;
        sector_buf[SIG_OFFSET + 1] = SIG_BYTE1;
    endtask

    task automatic set_entry(input int e, input logic [7:0] t, input logic [31:0] lba,
                             input logic [31:0] count);
        int base;
        begin
            base = TABLE_OFFSET + e * 16;
            sector_buf[base + 4] = t;
            for (int i = 0; i < 4; i++) begin
                sector_buf[base + 8 + i]  = lba[8 * i +: 8];
                sector_buf[base + 12 + i] = count[8 * i +: 8];
            end
        end
    endtask

    task automatic push_sector(input int len, input bit mark);
        item_t w;
        for (int i = 0; i < len; i++) begin
            w.byte_value   = sector_buf[i];
            w.sector_start = (i == 0) && mark;
            pending_words.push_back(w);
        end
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 12))
            0:       return TYPE_T39;
            1:       return TYPE_EXT2;
            2:       return TYPE_DOS0;
            3:       return TYPE_DOS1;
            4:       return TYPE_DOS2;
            5:       return TYPE_DOS3;
            6:       return TYPE_DOS4;
            7:       return TYPE_XLNK0;
            8:       return TYPE_XLNK1;
            9:       return TYPE_XLNK2;
            10:      return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_lba();
        case ($urandom_range(0, 4))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 65535));
            3:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start <= 1'b0;
            item  <= '0;
            burst_left = $urandom_range(1, 64);
            gap_left   = 0;
        end
        else begin
            if (start && !busy) begin
                predict_word(item);
                void'(pending_words.pop_front());
            end
            if (start && busy) begin
                // hold the word until taken
            end
            else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_words.size() != 0) begin
                start <= 1'b1;
                item  <= pending_words[0];
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 700)
                                                            : $urandom_range(1, 80);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(20, 60);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && result_valid) begin
            if (expected_words.size() == 0)
                report_mismatch("result word with none expected");
            else begin
                want = expected_words.pop_front();
                check_field("status", result.status, want.status);
                check_field("entry_number", result.entry_number, want.entry_number);
                check_field("kind", result.kind, want.kind);
                check_field("kind_index", result.kind_index, want.kind_index);
                check_field("is_extended", result.is_extended, want.is_extended);
                check_field("start_sector", result.start_sector, want.start_sector);
                check_field("length_sectors", result.length_sectors, want.length_sectors);
                check_field("end_sector", result.end_sector, want.end_sector);
                check_field("last_result", result.last_result, want.last_result);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int  kind_sel;
        bit  mark;
        bit  force_mark;

        for (int i = 0; i < TABLE_BYTES; i++)
            table_copy[i] = '0;

        // first sector straight out of reset, no start mark
        fill_sector(1'b1, 8'h00);
        set_entry(0, TYPE_T39, 32'h0000_0000, 32'h0000_0000);
        set_entry(1, TYPE_EXT2, 32'hFFFF_FFFF, 32'h0000_0001);
        set_entry(2, TYPE_DOS0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_entry(3, 8'h00, 32'h1234_5678, 32'h0000_0800);
        push_sector(SECTOR_BYTES, 1'b0);

        // four dos entries: index runs 0..3
        fill_sector(1'b1, 8'h00);
        set_entry(0, TYPE_DOS1, 32'h0000_003F, 32'h0001_0000);
        set_entry(1, TYPE_DOS2, 32'h8000_0000, 32'h8000_0000);
        set_entry(2, TYPE_DOS3, 32'h0000_0001, 32'hFFFF_FFFE);
        set_entry(3, TYPE_DOS4, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        push_sector(SECTOR_BYTES, 1'b1);

        // extended links and repeated kinds
        fill_sector(1'b1, 8'h00);
        set_entry(0, TYPE_XLNK0, 32'h0000_0800, 32'h0010_0000);
        set_entry(1, TYPE_XLNK1, 32'h7FFF_FFFF, 32'h0000_0001);
        set_entry(2, TYPE_XLNK2, 32'h0000_0000, 32'hFFFF_FFFF);
        set_entry(3, TYPE_T39, 32'h0000_0010, 32'h0000_0020);
        push_sector(SECTOR_BYTES, 1'b1);

        fill_sector(1'b1, 8'h00);
        set_entry(0, TYPE_EXT2, 32'h0000_0001, 32'h0000_0002);
        set_entry(1, TYPE_T39, 32'h0000_0003, 32'h0000_0004);
        set_entry(2, TYPE_EXT2, 32'h0000_0005, 32'h0000_0006);
        set_entry(3, TYPE_T39, 32'h0000_0007, 32'h0000_0008);
        push_sector(SECTOR_BYTES, 1'b1);

        // all ones and all zeros, signature intact
        fill_sector(1'b0, 8'hFF);
        push_sector(SECTOR_BYTES, 1'b1);
        fill_sector(1'b0, 8'h00);
        push_sector(SECTOR_BYTES, 1'b1);

        // missing signature variants
        fill_sector(1'b1, 8'h00);
        sector_buf[SIG_OFFSET + 1] = 8'h00;
        push_sector(SECTOR_BYTES, 1'b1);
        sector_buf[SIG_OFFSET]     = 8'h00;
        sector_buf[SIG_OFFSET + 1] = SIG_BYTE1;
        push_sector(SECTOR_BYTES, 1'b1);
        sector_buf[SIG_OFFSET]     = SIG_BYTE1;
        sector_buf[SIG_OFFSET + 1] = SIG_BYTE0;
        push_sector(SECTOR_BYTES, 1'b1);

        // sector cut short before, inside and after the table, then a full one
        fill_sector(1'b1, 8'h00);
        push_sector(300, 1'b1);
        push_sector(TABLE_OFFSET + 20, 1'b1);
        push_sector(505, 1'b1);
        push_sector(SECTOR_BYTES, 1'b1);

        // back-to-back sectors relying on position wrap
        fill_sector(1'b1, 8'h00);
        set_entry(1, TYPE_DOS0, 32'h0000_0100, 32'h0000_0200);
        push_sector(SECTOR_BYTES, 1'b1);
        set_entry(2, TYPE_DOS0, 32'h0000_0300, 32'h0000_0400);
        push_sector(SECTOR_BYTES, 1'b0);

        // random sectors, mostly well formed
        force_mark = 1'b0;
        for (int s = 0; s < RANDOM_SECTORS; s++) begin
            kind_sel = $urandom_range(0, 9);
            mark = force_mark || ($urandom_range(0, 3) != 0);
            force_mark = 1'b0;
            fill_sector(1'b1, 8'h00);
            for (int e = 0; e < 4; e++)
                set_entry(e, pick_type(), pick_lba(), pick_lba());
            case (kind_sel)
                0: begin
                    push_sector($urandom_range(1, SECTOR_BYTES - 1), 1'b1);
                    force_mark = 1'b1;
                end
                1: begin
                    sector_buf[SIG_OFFSET + $urandom_range(0, 1)] = 8'($urandom_range(0, 255));
                    push_sector(SECTOR_BYTES, mark);
                end
                2: begin
                    sector_buf[SIG_OFFSET]     = 8'($urandom_range(0, 255));
                    sector_buf[SIG_OFFSET + 1] = 8'($urandom_range(0, 255));
                    push_sector(SECTOR_BYTES, mark);
                end
                default: push_sector(SECTOR_BYTES, mark);
            endcase
        end
        if (force_mark) begin
            fill_sector(1'b1, 8'h00);
            push_sector(SECTOR_BYTES, 1'b1);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
sv/mbrpt_pkg.sv
sv/mbrpt_result_unit.sv
sv/mbr_partition_table_parser.sv
dv/tb_mbr_partition_table_parser.sv
